// ===== rtl/core/itol_pkg.sv =====
// ----------------------------------------------------------------------------
// itol_pkg: shared definitions for the indexed table with occupancy list
// Field widths, operation and type codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package itol_pkg;

	// Field widths of the request and response words.
	localparam int MODE_W = 2;
	localparam int KEY_W  = 6;
	localparam int TYPE_W = 3;
	localparam int DATA_W = 64;

	// Default table depth.
	localparam int CAPACITY_DEF = 64;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HEAD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NEXT = 2'd3;

	// Value type codes; codes above TYPE_PTR are not valid.
	localparam logic [TYPE_W-1:0] TYPE_NULL = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_BOOL = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_PTR  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // take the request word and read the stores
		logic clear;    // write one entry of the clearing pass
		logic exec;     // apply the update and load the response register
	} itol_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_done;  // the clearing pass is at its last entry
		logic out_busy;    // the response register holds a word not taken
	} itol_stat_t;

endpackage

// ===== rtl/core/itol_req_if.sv =====
// ----------------------------------------------------------------------------
// itol_req_if: request channel
// Valid/ready channel carrying one operation word to the table.
// ----------------------------------------------------------------------------
interface itol_req_if import itol_pkg::*; ;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [KEY_W-1:0]  key;
	logic [TYPE_W-1:0] value_type;
	logic [DATA_W-1:0] value_data;

	modport source (output valid, mode, key, value_type, value_data, input ready);
	modport sink (input valid, mode, key, value_type, value_data, output ready);

endinterface

// ===== rtl/core/itol_rsp_if.sv =====
// ----------------------------------------------------------------------------
// itol_rsp_if: response channel
// Valid/ready channel carrying one result word from the table.
// ----------------------------------------------------------------------------
interface itol_rsp_if import itol_pkg::*; ;

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] out_type;
	logic [DATA_W-1:0] out_data;
	logic [KEY_W-1:0]  link_key;
	logic              link_valid;
	logic              table_empty;

	modport source (output valid, out_type, out_data, link_key, link_valid, table_empty,
		input ready);
	modport sink (input valid, out_type, out_data, link_key, link_valid, table_empty,
		output ready);

endinterface

// ===== rtl/core/indexed_table_with_occupancy_list.sv =====
// Timing: an accepted word is captured with the stores' read data; the update
// cycle then loads the result word. A stalled result word holds the update back.
// Flow: no new word is accepted until the last one has been updated, as the
// link memories are read and then written for each word.
// Reset: asynchronous and active low; afterwards a clearing pass writes the null
// type into every entry, and no word is accepted during that pass.
// ----------------------------------------------------------------------------
// indexed_table_with_occupancy_list: key-indexed typed value table
// Stores a type and a 64-bit payload per key and keeps the occupied keys
// in a doubly linked list, newest at the head, for get, set and walk.
// ----------------------------------------------------------------------------
module indexed_table_with_occupancy_list import itol_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	itol_req_if.sink   req,
	itol_rsp_if.source rsp
);

	itol_cmd_t  cmd;
	itol_stat_t stat;

	// Sequencer.
	itol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Stores, links and response register.
	itol_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (req.mode),
		.key        (req.key),
		.value_type (req.value_type),
		.value_data (req.value_data),
		.rsp        (rsp)
	);

endmodule

// ===== rtl/core/itol_ctrl.sv =====
// ----------------------------------------------------------------------------
// itol_ctrl: operation sequencer
// Runs the clearing pass after reset, then takes one request word at a
// time: a read cycle followed by an update cycle.
// ----------------------------------------------------------------------------
module itol_ctrl import itol_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  itol_stat_t stat,
	output itol_cmd_t  cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clear_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (!stat.out_busy) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Commands to the datapath.
	assign req_ready   = (state_q == ST_IDLE);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.clear   = (state_q == ST_CLEAR);
	assign cmd.exec    = (state_q == ST_EXEC) && !stat.out_busy;

`ifndef NO_ASSERTIONS
	// A captured word always moves the sequencer to its update state.
	a_capture_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC))
		else $error("captured word did not reach the update state");

	// Capture and update never fall in the same cycle.
	a_capture_excl_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !cmd.capture)
		else $error("capture and update in the same cycle");

	// No word is accepted while the clearing pass runs.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !req_ready)
		else $error("word accepted during the clearing pass");
`endif

endmodule

// ===== rtl/core/itol_datapath.sv =====
// ----------------------------------------------------------------------------
// itol_datapath: stores, list pointers and response register
// Holds the type, payload and link memories and the head pointer. Reads
// happen when a word is captured; the update cycle writes at most one
// entry of each memory and loads the response register.
// ----------------------------------------------------------------------------
module itol_datapath import itol_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itol_cmd_t         cmd,
	output itol_stat_t        stat,
	input  logic [MODE_W-1:0] mode,
	input  logic [KEY_W-1:0]  key,
	input  logic [TYPE_W-1:0] value_type,
	input  logic [DATA_W-1:0] value_data,
	itol_rsp_if.source        rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = IW + 1;  // link: valid bit over index

	// Memories. Link entries are only read for occupied keys, and the
	// payload only where the type is not null, so neither needs clearing.
	logic [TYPE_W-1:0] type_mem  [CAPACITY];
	logic [DATA_W-1:0] data_mem  [CAPACITY];
	logic [LW-1:0]     next_mem  [CAPACITY];
	logic [LW-1:0]     prior_mem [CAPACITY];

	logic [LW-1:0]     head_q;
	logic [IW-1:0]     clr_q;

	// Captured request word and registered read data.
	logic [MODE_W-1:0] mode_q;
	logic [IW-1:0]     key_q;
	logic              in_range_q;
	logic [TYPE_W-1:0] vtype_q;
	logic [DATA_W-1:0] vdata_q;
	logic [TYPE_W-1:0] type_rd_q;
	logic [DATA_W-1:0] data_rd_q;
	logic [LW-1:0]     next_rd_q;
	logic [LW-1:0]     prior_rd_q;

	// Response register.
	logic              out_valid_q;
	logic [TYPE_W-1:0] out_type_q;
	logic [DATA_W-1:0] out_data_q;
	logic [KEY_W-1:0]  link_key_q;
	logic              link_valid_q;
	logic              table_empty_q;

	// Update decode.
	logic              occ;
	logic              is_head;
	logic              set_ok;
	logic              do_link;
	logic              do_unlink;
	logic [LW-1:0]     head_nxt;
	logic              type_we;
	logic [IW-1:0]     type_wa;
	logic [TYPE_W-1:0] type_wd;
	logic [DATA_W-1:0] data_wd;
	logic              next_we;
	logic [IW-1:0]     next_wa;
	logic [LW-1:0]     next_wd;
	logic              prior_we;
	logic [IW-1:0]     prior_wa;
	logic [LW-1:0]     prior_wd;
	logic [TYPE_W-1:0] res_type;
	logic [DATA_W-1:0] res_data;
	logic [KEY_W-1:0]  res_lkey;
	logic              res_lvalid;

	// Capture the request and read all four stores at its key.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= mode;
			key_q      <= IW'(key);
			in_range_q <= (32'(key) < 32'(CAPACITY));
			vtype_q    <= value_type;
			vdata_q    <= value_data;
			type_rd_q  <= type_mem[IW'(key)];
			data_rd_q  <= data_mem[IW'(key)];
			next_rd_q  <= next_mem[IW'(key)];
			prior_rd_q <= prior_mem[IW'(key)];
		end
	end

	// Decode the update. Only the head entry may have a stale prior link,
	// so the head is recognized by comparing against the head pointer.
	always_comb begin
		occ       = (type_rd_q != TYPE_NULL);
		is_head   = head_q[IW] && (head_q[IW-1:0] == key_q);
		set_ok    = (mode_q == MODE_SET) && in_range_q && (vtype_q <= TYPE_PTR);
		do_link   = set_ok && (vtype_q != TYPE_NULL) && !occ;
		do_unlink = set_ok && (vtype_q == TYPE_NULL) && occ;

		head_nxt = head_q;
		if (do_link) begin
			head_nxt = {1'b1, key_q};
		end else if (do_unlink && is_head) begin
			head_nxt = next_rd_q;
		end

		// Type store: the clearing pass or a set.
		type_we = cmd.clear || (cmd.exec && set_ok);
		type_wa = cmd.clear ? clr_q : key_q;
		type_wd = cmd.clear ? TYPE_NULL : vtype_q;

		// A boolean keeps bit 0 only.
		data_wd = (vtype_q == TYPE_BOOL) ? {{(DATA_W-1){1'b0}}, vdata_q[0]} : vdata_q;

		// Next links: new head points at the old head; an unlink bridges
		// the previous entry over the removed key.
		next_we = 1'b0;
		next_wa = key_q;
		next_wd = head_q;
		if (cmd.exec && do_unlink && !is_head) begin
			next_we = 1'b1;
			next_wa = prior_rd_q[IW-1:0];
			next_wd = next_rd_q;
		end else if (cmd.exec && do_link) begin
			next_we = 1'b1;
		end

		// Prior links: the old head learns its new predecessor; an unlink
		// points the following entry back at the previous one.
		prior_we = 1'b0;
		prior_wa = head_q[IW-1:0];
		prior_wd = {1'b1, key_q};
		if (cmd.exec && do_link && head_q[IW]) begin
			prior_we = 1'b1;
		end else if (cmd.exec && do_unlink && !is_head && next_rd_q[IW]) begin
			prior_we = 1'b1;
			prior_wa = next_rd_q[IW-1:0];
			prior_wd = prior_rd_q;
		end
	end

	// Memory writes.
	always_ff @(posedge clk) begin
		if (type_we) type_mem[type_wa] <= type_wd;
		if (cmd.exec && set_ok) data_mem[key_q] <= data_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prior_we) prior_mem[prior_wa] <= prior_wd;
	end

	// Response fields.
	always_comb begin
		res_type   = TYPE_NULL;
		res_data   = '0;
		res_lkey   = '0;
		res_lvalid = 1'b0;
		case (mode_q)
			MODE_GET: begin
				if (in_range_q) begin
					res_type = type_rd_q;
					res_data = occ ? data_rd_q : '0;
				end
			end
			MODE_HEAD: begin
				if (head_q[IW]) begin
					res_lkey   = KEY_W'(head_q[IW-1:0]);
					res_lvalid = 1'b1;
				end
			end
			MODE_NEXT: begin
				if (in_range_q && occ && next_rd_q[IW]) begin
					res_lkey   = KEY_W'(next_rd_q[IW-1:0]);
					res_lvalid = 1'b1;
				end
			end
			default: begin
				res_lvalid = 1'b0;
			end
		endcase
	end

	// Head pointer, clearing counter and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) head_q <= head_nxt;
			if (cmd.clear) clr_q <= IW'(clr_q + 1'b1);
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_type_q    <= res_type;
			out_data_q    <= res_data;
			link_key_q    <= res_lkey;
			link_valid_q  <= res_lvalid;
			table_empty_q <= !head_nxt[IW];
		end
	end

	assign stat.clear_done = (clr_q == IW'(CAPACITY - 1));
	assign stat.out_busy   = out_valid_q && !rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.out_type    = out_type_q;
	assign rsp.out_data    = out_data_q;
	assign rsp.link_key    = link_key_q;
	assign rsp.link_valid  = link_valid_q;
	assign rsp.table_empty = table_empty_q;

`ifndef NO_ASSERTIONS
	// A key that is not occupied can never be the head of the list.
	a_link_not_head: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && do_link) |-> !is_head)
		else $error("linking a key that is already the list head");

	// An update cycle always leaves a word in the response register.
	a_exec_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("update cycle did not load the response register");

	// The update never overwrites a response word that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !cmd.exec)
		else $error("response word overwritten before it was taken");
`endif

endmodule
